[rtl/assert_macros.svh]
// Assertion macros used by the motor controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/sdmc_pkg.sv]
`default_nettype none

package sdmc_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [2:0] event_t;

  localparam int unsigned COUNT_BITS_DEFAULT = 16;
  localparam int unsigned STALL_BITS = 16;
  localparam int unsigned CAL_OUT_BITS = 16;
  localparam logic [STALL_BITS-1:0] STALL_MAX = 16'hFFFF;
  localparam logic [STALL_BITS-1:0] STALL_LIMIT_RESET = 16'd100;

  localparam mode_t FUNC_TICK    = 2'd0;
  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_CAL     = 2'd1;
  localparam mode_t MODE_COUNTED = 2'd2;
  localparam mode_t MODE_LIMIT   = 2'd3;

  localparam logic [1:0] HITS_DONE = 2'd3;

  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_CAL_DONE = 3'd1;
  localparam event_t EV_REACHED  = 3'd2;
  localparam event_t EV_STOPPED  = 3'd3;
  localparam event_t EV_STALLED  = 3'd4;

  // Half-step coil pattern for each of the eight phases.
  function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
    logic [3:0] pat;
    unique case (phase)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[rtl/stepper_door_motor_controller.sv]
// Channel   Direction  Ports                         Request
// in        input      in_valid / in_ready           one tick or start command
// out       output     out_valid / out_ready         one result per request
// cfg       input      cfg_valid / cfg_ready         stall limit write
//
// Each request is processed combinationally and its result is held in the output register.
// A new request is accepted every cycle while the output register is empty or being read.
// A stall on out_ready holds the result and blocks in_ready; cfg_ready is always high.
// Synchronous active-low reset returns the run to idle and the stall limit to 100.
`default_nettype none
`include "assert_macros.svh"

module stepper_door_motor_controller #(
  parameter int unsigned COUNT_BITS = sdmc_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_func,
  input  wire logic                                in_reverse,
  input  wire logic                                in_door_value,
  input  wire logic                                in_limit_close,
  input  wire logic                                in_limit_open,
  input  wire logic                                in_encoder_pulse,
  input  wire logic                                in_stop_press,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [3:0]                               out_coils,
  output logic                                     out_stepped,
  output logic                                     out_busy_res,
  output logic [2:0]                               out_event_res,
  output logic                                     out_door_write_valid,
  output logic                                     out_door_write_value,
  output logic                                     out_between_write_valid,
  output logic                                     out_between_value,
  output logic [sdmc_pkg::CAL_OUT_BITS-1:0]        out_calibrated_steps,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sdmc_pkg::STALL_BITS-1:0]     cfg_stall_limit_ticks
);
  import sdmc_pkg::*;

  logic [STALL_BITS-1:0]   stall_limit_r;
  logic [2:0]              phase_r, phase_nxt;
  mode_t                   mode_r, mode_nxt;
  logic                    dir_r, dir_nxt;
  logic [COUNT_BITS-1:0]   move_r, move_nxt;
  logic [COUNT_BITS:0]     total_r, total_nxt;
  logic [1:0]              hit_r, hit_nxt, hit_mid;
  logic                    close_l_r, close_l_nxt;
  logic                    open_l_r, open_l_nxt;
  logic [STALL_BITS-1:0]   stall_r, stall_nxt;
  logic [COUNT_BITS-1:0]   target_r, target_nxt;
  logic                    held_r, held_nxt;

  logic                    c_hit, o_hit, stalled, step;
  event_t                  event_nxt;
  logic                    dw_valid, dw_value, bw_valid, bw_value;
  logic [CAL_OUT_BITS-1:0] cal_nxt;

  logic                    out_valid_r;
  logic [3:0]              coils_r;
  logic                    stepped_r, busy_r, dwv_r, dwval_r, bwv_r, bwval_r;
  event_t                  event_r;
  logic [CAL_OUT_BITS-1:0] cal_r;

  logic                    accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    mode_nxt    = mode_r;
    dir_nxt     = dir_r;
    move_nxt    = move_r;
    total_nxt   = total_r;
    hit_nxt     = hit_r;
    hit_mid     = hit_r;
    close_l_nxt = close_l_r;
    open_l_nxt  = open_l_r;
    stall_nxt   = stall_r;
    target_nxt  = target_r;
    held_nxt    = held_r;
    event_nxt   = EV_NONE;
    dw_valid    = 1'b0;
    dw_value    = 1'b0;
    bw_valid    = 1'b0;
    bw_value    = 1'b0;
    step        = 1'b0;
    c_hit       = in_limit_close && !close_l_r;
    o_hit       = in_limit_open && !open_l_r;
    stalled     = 1'b0;

    if (in_func != FUNC_TICK) begin
      mode_nxt  = in_func;
      dir_nxt   = in_reverse;
      move_nxt  = '0;
      total_nxt = '0;
      hit_nxt   = '0;
      stall_nxt = '0;
      if (in_func == MODE_CAL) begin
        close_l_nxt = 1'b0;
        open_l_nxt  = 1'b0;
      end
      if (in_func == MODE_COUNTED) begin
        held_nxt = in_door_value;
      end
    end else if (mode_r != MODE_IDLE) begin
      if (in_encoder_pulse) begin
        stall_nxt = '0;
      end else if (stall_r != STALL_MAX) begin
        stall_nxt = stall_r + 1'b1;
      end
      stalled = (stall_nxt >= stall_limit_r);

      if (stalled) begin
        event_nxt = EV_STALLED;
        mode_nxt  = MODE_IDLE;
      end else begin
        unique case (mode_r)
          MODE_CAL: begin
            if (hit_r == HITS_DONE) begin
              target_nxt = total_r[COUNT_BITS:1];
              event_nxt  = EV_CAL_DONE;
              mode_nxt   = MODE_IDLE;
            end else begin
              hit_mid     = (c_hit && hit_r != HITS_DONE) ? hit_r + 2'd1 : hit_r;
              hit_nxt     = (o_hit && hit_mid != HITS_DONE) ? hit_mid + 2'd1 : hit_mid;
              dir_nxt     = dir_r ^ c_hit ^ o_hit;
              close_l_nxt = in_limit_close;
              open_l_nxt  = in_limit_open;
              if (c_hit || o_hit) begin
                stall_nxt = '0;
              end
              if (hit_nxt != 2'd0 && !(&total_r)) begin
                total_nxt = total_r + 1'b1;
              end
              step = 1'b1;
            end
          end
          MODE_COUNTED: begin
            if (in_stop_press) begin
              event_nxt = EV_STOPPED;
              mode_nxt  = MODE_IDLE;
            end else if (move_r >= target_r) begin
              dw_valid  = 1'b1;
              dw_value  = held_r;
              event_nxt = EV_REACHED;
              mode_nxt  = MODE_IDLE;
            end else begin
              step     = 1'b1;
              move_nxt = move_r + 1'b1;
            end
          end
          MODE_LIMIT: begin
            if (in_stop_press) begin
              bw_valid  = 1'b1;
              bw_value  = !dir_r;
              event_nxt = EV_STOPPED;
              mode_nxt  = MODE_IDLE;
            end else if (dir_r ? in_limit_close : in_limit_open) begin
              dw_valid  = 1'b1;
              dw_value  = dir_r;
              event_nxt = EV_REACHED;
              mode_nxt  = MODE_IDLE;
            end else begin
              step = 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end

    if (step) begin
      phase_nxt = dir_nxt ? phase_r - 3'd1 : phase_r + 3'd1;
    end
  end

  generate
    if (COUNT_BITS >= CAL_OUT_BITS) begin : g_cal_trunc
      assign cal_nxt = target_nxt[CAL_OUT_BITS-1:0];
    end else begin : g_cal_pad
      assign cal_nxt = {{(CAL_OUT_BITS-COUNT_BITS){1'b0}}, target_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_limit_r <= STALL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stall_limit_r <= cfg_stall_limit_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      mode_r    <= MODE_IDLE;
      dir_r     <= 1'b0;
      move_r    <= '0;
      total_r   <= '0;
      hit_r     <= '0;
      close_l_r <= 1'b0;
      open_l_r  <= 1'b0;
      stall_r   <= '0;
      target_r  <= '0;
      held_r    <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      mode_r    <= mode_nxt;
      dir_r     <= dir_nxt;
      move_r    <= move_nxt;
      total_r   <= total_nxt;
      hit_r     <= hit_nxt;
      close_l_r <= close_l_nxt;
      open_l_r  <= open_l_nxt;
      stall_r   <= stall_nxt;
      target_r  <= target_nxt;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coils_r   <= coil_pattern(phase_nxt);
      stepped_r <= step;
      busy_r    <= (mode_nxt != MODE_IDLE);
      event_r   <= event_nxt;
      dwv_r     <= dw_valid;
      dwval_r   <= dw_value;
      bwv_r     <= bw_valid;
      bwval_r   <= bw_value;
      cal_r     <= cal_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_coils               = coils_r;
  assign out_stepped             = stepped_r;
  assign out_busy_res            = busy_r;
  assign out_event_res           = event_r;
  assign out_door_write_valid    = dwv_r;
  assign out_door_write_value    = dwval_r;
  assign out_between_write_valid = bwv_r;
  assign out_between_value       = bwval_r;
  assign out_calibrated_steps    = cal_r;

  `ASSERT_IMPLY(a_step_keeps_run, clk, rst_n, out_valid_r && stepped_r, busy_r)
  `ASSERT_IMPLY(a_event_ends_run, clk, rst_n, out_valid_r && (event_r != EV_NONE), !busy_r)
  `ASSERT_IMPLY(a_door_write_on_reach, clk, rst_n, out_valid_r && dwv_r, event_r == EV_REACHED)
  `ASSERT_IMPLY(a_between_on_stop, clk, rst_n, out_valid_r && bwv_r, event_r == EV_STOPPED)
  `ASSERT_NEXT(a_idle_tick_quiet, clk, rst_n,
    accept && (in_func == FUNC_TICK) && (mode_r == MODE_IDLE),
    out_valid_r && !stepped_r && (event_r == EV_NONE) && !busy_r)

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sdmc_pkg::*;

  typedef struct packed {
    mode_t func;
    logic  reverse;
    logic  door_value;
    logic  limit_close;
    logic  limit_open;
    logic  encoder_pulse;
    logic  stop_press;
  } motor_cmd_t;

  typedef struct packed {
    logic [3:0]  coils;
    logic        stepped;
    logic        busy;
    event_t      ev;
    logic        door_wr;
    logic        door_val;
    logic        between_wr;
    logic        between_val;
    logic [15:0] cal_steps;
  } motor_out_t;

  // Half-step coil drive, phase 0 in the low nibble.
  localparam logic [31:0] COIL_SEQ = 32'h98C4_6231;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mode_t       in_func = FUNC_TICK;
  logic        in_reverse = 1'b0;
  logic        in_door_value = 1'b0;
  logic        in_limit_close = 1'b0;
  logic        in_limit_open = 1'b0;
  logic        in_encoder_pulse = 1'b0;
  logic        in_stop_press = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_coils;
  logic        out_stepped;
  logic        out_busy_res;
  logic [2:0]  out_event_res;
  logic        out_door_write_valid;
  logic        out_door_write_value;
  logic        out_between_write_valid;
  logic        out_between_value;
  logic [15:0] out_calibrated_steps;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_stall_limit_ticks = STALL_LIMIT_RESET;

  stepper_door_motor_controller u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_func                 (in_func),
    .in_reverse              (in_reverse),
    .in_door_value           (in_door_value),
    .in_limit_close          (in_limit_close),
    .in_limit_open           (in_limit_open),
    .in_encoder_pulse        (in_encoder_pulse),
    .in_stop_press           (in_stop_press),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_coils               (out_coils),
    .out_stepped             (out_stepped),
    .out_busy_res            (out_busy_res),
    .out_event_res           (out_event_res),
    .out_door_write_valid    (out_door_write_valid),
    .out_door_write_value    (out_door_write_value),
    .out_between_write_valid (out_between_write_valid),
    .out_between_value       (out_between_value),
    .out_calibrated_steps    (out_calibrated_steps),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_stall_limit_ticks   (cfg_stall_limit_ticks)
  );

  motor_out_t pending_outputs[$];
  int         error_count = 0;
  int         result_count = 0;
  int         active_items = 0;
  bit         steady = 1'b0;
  int         ready_hold = 0;

  // Predicted controller state.
  logic [15:0] stall_limit;
  logic [2:0]  phase;
  mode_t       run_mode;
  logic        closing;
  logic [15:0] moved;
  logic [16:0] cal_total;
  logic [1:0]  hits;
  logic        close_seen;
  logic        open_seen;
  logic [15:0] idle_ticks;
  logic [15:0] span_steps;
  logic        door_on_done;

  function automatic void reset_motor_state();
    stall_limit = STALL_LIMIT_RESET;
    phase = '0;
    run_mode = MODE_IDLE;
    closing = 1'b0;
    moved = '0;
    cal_total = '0;
    hits = '0;
    close_seen = 1'b0;
    open_seen = 1'b0;
    idle_ticks = '0;
    span_steps = '0;
    door_on_done = 1'b0;
  endfunction

  function automatic void step_phase();
    phase = closing ? phase - 3'd1 : phase + 3'd1;
  endfunction

  function automatic motor_out_t door_motor_step(input motor_cmd_t c);
    motor_out_t o;
    o = '0;
    if (c.func != FUNC_TICK) begin
      run_mode = c.func;
      closing = c.reverse;
      moved = '0;
      cal_total = '0;
      hits = '0;
      idle_ticks = '0;
      if (c.func == MODE_CAL) begin
        close_seen = 1'b0;
        open_seen = 1'b0;
      end
      if (c.func == MODE_COUNTED) door_on_done = c.door_value;
    end else if (run_mode != MODE_IDLE) begin
      if (c.encoder_pulse) idle_ticks = '0;
      else if (idle_ticks != STALL_MAX) idle_ticks = idle_ticks + 16'd1;
      if (idle_ticks >= stall_limit) begin
        o.ev = EV_STALLED;
        run_mode = MODE_IDLE;
      end else if (run_mode == MODE_CAL) begin
        if (hits == HITS_DONE) begin
          span_steps = cal_total[16:1];
          o.ev = EV_CAL_DONE;
          run_mode = MODE_IDLE;
        end else begin
          if (c.limit_close && !close_seen) begin
            if (hits != HITS_DONE) hits = hits + 2'd1;
            closing = ~closing;
            close_seen = 1'b1;
            idle_ticks = '0;
          end else if (!c.limit_close) begin
            close_seen = 1'b0;
          end
          if (c.limit_open && !open_seen) begin
            if (hits != HITS_DONE) hits = hits + 2'd1;
            closing = ~closing;
            open_seen = 1'b1;
            idle_ticks = '0;
          end else if (!c.limit_open) begin
            open_seen = 1'b0;
          end
          if (hits != 2'd0 && cal_total != '1) cal_total = cal_total + 17'd1;
          step_phase();
          o.stepped = 1'b1;
        end
      end else if (run_mode == MODE_COUNTED) begin
        if (c.stop_press) begin
          o.ev = EV_STOPPED;
          run_mode = MODE_IDLE;
        end else if (moved >= span_steps) begin
          o.door_wr = 1'b1;
          o.door_val = door_on_done;
          o.ev = EV_REACHED;
          run_mode = MODE_IDLE;
        end else begin
          step_phase();
          o.stepped = 1'b1;
          moved = moved + 16'd1;
        end
      end else begin
        if (c.stop_press) begin
          o.between_wr = 1'b1;
          o.between_val = ~closing;
          o.ev = EV_STOPPED;
          run_mode = MODE_IDLE;
        end else if (closing ? c.limit_close : c.limit_open) begin
          o.door_wr = 1'b1;
          o.door_val = closing;
          o.ev = EV_REACHED;
          run_mode = MODE_IDLE;
        end else begin
          step_phase();
          o.stepped = 1'b1;
        end
      end
    end
    o.coils = COIL_SEQ[phase * 4 +: 4];
    o.busy = (run_mode != MODE_IDLE);
    o.cal_steps = span_steps;
    return o;
  endfunction

  function automatic motor_cmd_t cmd(input mode_t f, input int unsigned rev,
                                     input int unsigned dv, input int unsigned lc,
                                     input int unsigned lo, input int unsigned ep,
                                     input int unsigned sp);
    motor_cmd_t c;
    c.func = f;
    c.reverse = rev[0];
    c.door_value = dv[0];
    c.limit_close = lc[0];
    c.limit_open = lo[0];
    c.encoder_pulse = ep[0];
    c.stop_press = sp[0];
    return c;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 100) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d, %s: got %0h, expected %0h",
                           result_count, name, got, want));
  endtask

  task automatic send_cmd(input motor_cmd_t c);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= c.func;
    in_reverse <= c.reverse;
    in_door_value <= c.door_value;
    in_limit_close <= c.limit_close;
    in_limit_open <= c.limit_open;
    in_encoder_pulse <= c.encoder_pulse;
    in_stop_press <= c.stop_press;
    do @(posedge clk); while (!in_ready);
    if (c.func != FUNC_TICK || run_mode != MODE_IDLE) active_items++;
    pending_outputs.push_back(door_motor_step(c));
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_outputs.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_outputs.size()));
      pending_outputs.delete();
    end
  endtask

  task automatic set_stall_limit(input logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_stall_limit_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    stall_limit = v;
  endtask

  task automatic test_directed_runs();
    // An idle tick changes nothing, whatever the other fields say.
    send_cmd(cmd(FUNC_TICK, 1, 1, 1, 1, 1, 1));
    // Move to the open end; the stop on the start request is ignored.
    send_cmd(cmd(MODE_LIMIT, 0, 0, 0, 0, 1, 1));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 1, 1, 0));
    // Stopped between the ends, first closing and then opening.
    send_cmd(cmd(MODE_LIMIT, 1, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1));
    send_cmd(cmd(MODE_LIMIT, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 1, 1, 1, 0, 1, 1));
    // A counted move with a zero target completes at once.
    send_cmd(cmd(MODE_COUNTED, 0, 1, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    // Calibration with the close switch already pressed, a stop that is
    // ignored, and both switches rising together.
    send_cmd(cmd(MODE_CAL, 0, 0, 1, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 1));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 1, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 1, 1, 0));
    send_cmd(cmd(MODE_COUNTED, 1, 1, 0, 0, 1, 0));
    repeat (3) send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    // A new start replaces the running move.
    send_cmd(cmd(MODE_LIMIT, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(MODE_COUNTED, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 1));
    // A limit hit clears the stall count; the stalled calibration keeps its count.
    set_stall_limit(16'd2);
    send_cmd(cmd(MODE_CAL, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 0, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 0, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 0, 0));
    set_stall_limit(16'd0);
    send_cmd(cmd(MODE_LIMIT, 1, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    set_stall_limit(16'd1);
    send_cmd(cmd(MODE_LIMIT, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    set_stall_limit(16'hFFFF);
    send_cmd(cmd(MODE_COUNTED, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    set_stall_limit(STALL_LIMIT_RESET);
  endtask

  task automatic test_backpressure();
    settle();
    steady = 1'b1;
    ready_hold = 60;
    send_cmd(cmd(MODE_LIMIT, 0, 0, 0, 0, 1, 0));
    repeat (30) send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    steady = 1'b0;
  endtask

  task automatic drive_run(input mode_t kind);
    motor_cmd_t c;
    int unsigned lc;
    int unsigned lo;
    int ticks;
    lc = $urandom_range(1);
    lo = $urandom_range(1);
    ticks = 0;
    send_cmd(cmd(kind, $urandom_range(1), $urandom_range(1), lc, lo,
                 $urandom_range(1), $urandom_range(1)));
    while (run_mode != MODE_IDLE && ticks < 250) begin
      if ($urandom_range(5) == 0) lc ^= 1;
      if ($urandom_range(5) == 0) lo ^= 1;
      c = cmd(FUNC_TICK, $urandom_range(1), $urandom_range(1), lc, lo,
              ($urandom_range(9) != 0) ? 1 : 0, ($urandom_range(29) == 0) ? 1 : 0);
      send_cmd(c);
      ticks++;
    end
  endtask

  task automatic random_limit_change();
    case ($urandom_range(4))
      0: set_stall_limit(16'd1);
      1: set_stall_limit(16'hFFFF);
      2: set_stall_limit(16'($urandom_range(12, 2)));
      3: set_stall_limit(16'($urandom_range(65534, 13)));
      default: set_stall_limit(STALL_LIMIT_RESET);
    endcase
  endtask

  task automatic random_mix(input int goal);
    int stop_at;
    stop_at = active_items + goal;
    while (active_items < stop_at) begin
      if ($urandom_range(9) == 0) random_limit_change();
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(8, 1))
          send_cmd(cmd(mode_t'($urandom_range(3)), $urandom_range(1), $urandom_range(1),
                       $urandom_range(1), $urandom_range(1), $urandom_range(1),
                       $urandom_range(1)));
      end else begin
        drive_run(mode_t'($urandom_range(3, 1)));
      end
    end
  endtask

  task automatic test_random_runs();
    random_mix(1250);
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    random_mix(300);
    steady = 1'b0;
  endtask

  // Runs a longer calibration, a counted move over the calibrated length, and
  // a move to the limit that stalls without encoder pulses.
  task automatic test_long_runs();
    set_stall_limit(STALL_LIMIT_RESET);
    steady = 1'b1;
    send_cmd(cmd(MODE_CAL, 0, 0, 1, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 1, 0));
    repeat (150) send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 0, 1, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 1, 0));
    send_cmd(cmd(FUNC_TICK, 0, 0, 1, 0, 1, 0));
    send_cmd(cmd(MODE_COUNTED, 0, 1, 0, 0, 1, 0));
    while (run_mode != MODE_IDLE) send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 1, 0));
    send_cmd(cmd(MODE_LIMIT, 1, 0, 0, 0, 0, 0));
    while (run_mode != MODE_IDLE) send_cmd(cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    steady = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin : result_checker
    motor_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          flag_error("result arrived with no request pending");
        end else begin
          want = pending_outputs.pop_front();
          check_field("coils", 32'(out_coils), 32'(want.coils));
          check_field("stepped", 32'(out_stepped), 32'(want.stepped));
          check_field("busy", 32'(out_busy_res), 32'(want.busy));
          check_field("event", 32'(out_event_res), 32'(want.ev));
          check_field("door write valid", 32'(out_door_write_valid),
                      32'(want.door_wr));
          check_field("door write value", 32'(out_door_write_value),
                      32'(want.door_val));
          check_field("between write valid", 32'(out_between_write_valid),
                      32'(want.between_wr));
          check_field("between value", 32'(out_between_value),
                      32'(want.between_val));
          check_field("calibrated steps", 32'(out_calibrated_steps),
                      32'(want.cal_steps));
        end
        result_count++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("** stepper_door_motor_controller: FAILED **");
    $finish;
  end

  initial begin
    reset_motor_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_runs();
    test_backpressure();
    test_random_runs();
    test_steady_stream();
    test_long_runs();
    settle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("** stepper_door_motor_controller: PASSED **");
    end else begin
      $display("** stepper_door_motor_controller: FAILED **");
    end
    $finish;
  end

endmodule
